@@ rtl/core/imu_bias_calibrate_launch_integrate_defines.svh @@
// Assertion macros shared by the IMU calibration and integration block.
// Needs only a clock and an active-low reset in the including module.
`ifndef IMU_BIAS_CALIBRATE_LAUNCH_INTEGRATE_DEFINES_SVH
`define IMU_BIAS_CALIBRATE_LAUNCH_INTEGRATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMUBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IMUBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/imubc_pkg.sv @@
// Types and constants of the IMU calibration and integration block.
// No dependencies; used by every module of the block.
package imubc_pkg;

  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned DT_W       = 24;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned DEN_W      = CNT_W + 1;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NUM_LANES  = 6;

  localparam logic [CFG_ADDR_W-1:0] CFG_CALIB_SAMPLES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LAUNCH_THRESH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DT_STEP       = 2'd2;

  localparam logic [CNT_W-1:0]          RST_CALIB_SAMPLES = 16'd2000;
  localparam logic signed [FIELD_W-1:0] RST_LAUNCH_THRESH = -32'sd969933;
  localparam logic [DT_W-1:0]           RST_DT_STEP       = 24'd33554;

  typedef struct packed {
    logic signed [FIELD_W-1:0] accel_x;
    logic signed [FIELD_W-1:0] accel_y;
    logic signed [FIELD_W-1:0] accel_z;
    logic signed [FIELD_W-1:0] gyro_x;
    logic signed [FIELD_W-1:0] gyro_y;
    logic signed [FIELD_W-1:0] gyro_z;
  } imu_in_t;

  typedef struct packed {
    logic                      launched;
    logic [FIELD_W-1:0]        flight_ticks;
    logic signed [FIELD_W-1:0] rate_x;
    logic signed [FIELD_W-1:0] rate_y;
    logic signed [FIELD_W-1:0] rate_z;
    logic signed [FIELD_W-1:0] acc_out_x;
    logic signed [FIELD_W-1:0] acc_out_y;
    logic signed [FIELD_W-1:0] acc_out_z;
    logic signed [FIELD_W-1:0] roll;
    logic signed [FIELD_W-1:0] pitch;
    logic signed [FIELD_W-1:0] yaw;
  } imu_out_t;

  typedef struct packed {
    logic             accum;
    logic             div_start;
    logic             div_step;
    logic             div_finish;
    logic             correct;
    logic             mul;
    logic             integ;
    logic [DEN_W-1:0] den;
  } lane_ctrl_t;

endpackage

@@ rtl/core/imubc_lane.sv @@
// One axis lane: saturating sum, serial bias divider and bias correction.
// Depends on imubc_pkg for the lane control struct and field widths.
module imubc_lane #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned SUM_WIDTH    = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  imubc_pkg::lane_ctrl_t          ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] corrected_o
);
  import imubc_pkg::*;

  localparam int unsigned DIFF_W = FIELD_W + 2;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [DIFF_W-1:0] CORR_MAX =
    DIFF_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [DIFF_W-1:0] CORR_MIN = -CORR_MAX - DIFF_W'(1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SUM_WIDTH-1:0]    sum_q, sum_d;
  logic signed [SUM_WIDTH:0]      sum_wide;
  logic signed [FIELD_W-1:0]      bias_q, bias_d;
  logic [SUM_WIDTH-1:0]           sum_mag;
  logic [SUM_WIDTH-1:0]           quo_q, quo_d;
  logic [DEN_W-1:0]               rem_q, rem_d;
  logic [DEN_W:0]                 rem_sh;
  logic [DEN_W:0]                 rem_sub;
  logic                           fits;
  logic                           neg_q, neg_d;
  logic [63:0]                    mag64;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [SAMPLE_WIDTH-1:0] corrected_q, corrected_d;

  always_comb begin
    sum_wide = (SUM_WIDTH+1)'(sum_q) + (SUM_WIDTH+1)'(sample_i);
    sum_d    = sum_q;
    if (ctrl_i.accum) begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
        sum_d = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
        sum_d = sum_wide[SUM_WIDTH-1:0];
      end
    end
  end

  assign sum_mag = sum_q[SUM_WIDTH-1] ? (~sum_q + SUM_WIDTH'(1)) : sum_q;
  assign rem_sh  = {rem_q, quo_q[SUM_WIDTH-1]};
  assign fits    = rem_sh >= {1'b0, ctrl_i.den};
  assign rem_sub = rem_sh - {1'b0, ctrl_i.den};
  assign mag64   = 64'(quo_q);

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    bias_d = bias_q;
    if (ctrl_i.div_start) begin
      quo_d = sum_mag;
      rem_d = '0;
      neg_d = sum_q[SUM_WIDTH-1];
    end else if (ctrl_i.div_step) begin
      quo_d = {quo_q[SUM_WIDTH-2:0], fits};
      rem_d = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end else if (ctrl_i.div_finish) begin
      if (neg_q) begin
        if ((|mag64[63:32]) || (mag64[31] && (|mag64[30:0]))) begin
          bias_d = {1'b1, {(FIELD_W-1){1'b0}}};
        end else begin
          bias_d = -$signed(mag64[31:0]);
        end
      end else begin
        if (|mag64[63:31]) begin
          bias_d = {1'b0, {(FIELD_W-1){1'b1}}};
        end else begin
          bias_d = $signed(mag64[31:0]);
        end
      end
    end
  end

  always_comb begin
    diff        = DIFF_W'(sample_i) - DIFF_W'(bias_q);
    corrected_d = corrected_q;
    if (ctrl_i.correct) begin
      if (diff > CORR_MAX) begin
        corrected_d = SMP_MAX;
      end else if (diff < CORR_MIN) begin
        corrected_d = SMP_MIN;
      end else begin
        corrected_d = diff[SAMPLE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      bias_q <= '0;
    end else begin
      sum_q  <= sum_d;
      bias_q <= bias_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    neg_q       <= neg_d;
    corrected_q <= corrected_d;
  end

  assign corrected_o = corrected_q;

endmodule

@@ rtl/core/imubc_integ.sv @@
// Angle integrator of one gyro lane: multiply by the time step, round, saturate.
// Depends on imubc_pkg for the lane control struct and field widths.
module imubc_integ #(
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  imubc_pkg::lane_ctrl_t          ctrl_i,
  input  logic [imubc_pkg::DT_W-1:0]     dt_i,
  input  logic signed [SAMPLE_WIDTH-1:0] rate_i,
  output logic signed [imubc_pkg::FIELD_W-1:0] angle_o
);
  import imubc_pkg::*;

  localparam int unsigned PROD_W = DT_W + 1 + SAMPLE_WIDTH;
  localparam int unsigned ACC_W  = FIELD_W + DT_W + 2;
  localparam int unsigned Q_W    = ACC_W - DT_W;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(64'sd1 <<< (DT_W - 1));

  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc;
  logic signed [Q_W-1:0]     quot;
  logic signed [FIELD_W-1:0] angle_q, angle_d;

  assign prod_d = $signed({1'b0, dt_i}) * rate_i;
  assign acc    = $signed({angle_q, {DT_W{1'b0}}}) + ACC_W'(prod_q) + ROUND;
  assign quot   = acc[ACC_W-1:DT_W];

  always_comb begin
    angle_d = angle_q;
    if (ctrl_i.integ) begin
      if (quot[Q_W-1:FIELD_W-1] == {(Q_W-FIELD_W+1){1'b0}} ||
          quot[Q_W-1:FIELD_W-1] == {(Q_W-FIELD_W+1){1'b1}}) begin
        angle_d = quot[FIELD_W-1:0];
      end else if (quot[Q_W-1]) begin
        angle_d = {1'b1, {(FIELD_W-1){1'b0}}};
      end else begin
        angle_d = {1'b0, {(FIELD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

@@ rtl/core/imu_bias_calibrate_launch_integrate.sv @@
// Path of an accepted item: CALC and DONE before launch, CALC, MUL, INTEG and DONE after;
// CALC, DIV_INIT, DIV, FIX and DONE for the launch item, whose serial bias divider takes
// one bit a cycle. One transaction is in work at a time; the input stalls outside IDLE.
// Reset clears sums, biases, angles, counters, the launch flag and loads register defaults.
// Top level: control sequencer, six axis lanes, three integrators and the output merge.
// Depends on imubc_pkg, imubc_lane, imubc_integ and the assertion macro header.
module imu_bias_calibrate_launch_integrate #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned SUM_WIDTH    = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [imubc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [imubc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  imubc_pkg::imu_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output imubc_pkg::imu_out_t                  out_data_o
);
  import imubc_pkg::*;

  `include "imu_bias_calibrate_launch_integrate_defines.svh"

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CALC     = 3'd1;
  localparam logic [2:0] ST_DIV_INIT = 3'd2;
  localparam logic [2:0] ST_DIV      = 3'd3;
  localparam logic [2:0] ST_FIX      = 3'd4;
  localparam logic [2:0] ST_MUL      = 3'd5;
  localparam logic [2:0] ST_INTEG    = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  localparam int unsigned DCNT_W = $clog2(SUM_WIDTH);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(SUM_WIDTH - 1);

  logic [CNT_W-1:0]          calib_samples_q;
  logic signed [FIELD_W-1:0] thresh_q;
  logic [DT_W-1:0]           dt_q;

  logic [2:0]                state_q, state_d;
  logic [DCNT_W-1:0]         dcnt_q, dcnt_d;
  logic [CNT_W-1:0]          calib_count_q, calib_count_d;
  logic                      launch_q, launch_d;
  logic [FIELD_W-1:0]        tick_q, tick_d;
  logic                      post_q, post_d;
  imu_in_t                   in_q;
  logic                      launch_now;
  lane_ctrl_t                ctrl;

  logic signed [SAMPLE_WIDTH-1:0] smp  [NUM_LANES];
  logic signed [SAMPLE_WIDTH-1:0] corr [NUM_LANES];
  logic signed [SAMPLE_WIDTH-1:0] sel  [NUM_LANES];
  logic signed [FIELD_W-1:0]      angle [3];

  logic     out_valid_q, out_valid_d;
  imu_out_t out_q, out_d;
  logic     load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_samples_q <= RST_CALIB_SAMPLES;
      thresh_q        <= RST_LAUNCH_THRESH;
      dt_q            <= RST_DT_STEP;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_CALIB_SAMPLES: calib_samples_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_LAUNCH_THRESH: thresh_q        <= $signed(cfg_wdata_i[FIELD_W-1:0]);
        CFG_DT_STEP:       dt_q            <= cfg_wdata_i[DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign smp[0] = in_q.accel_x[SAMPLE_WIDTH-1:0];
  assign smp[1] = in_q.accel_y[SAMPLE_WIDTH-1:0];
  assign smp[2] = in_q.accel_z[SAMPLE_WIDTH-1:0];
  assign smp[3] = in_q.gyro_x[SAMPLE_WIDTH-1:0];
  assign smp[4] = in_q.gyro_y[SAMPLE_WIDTH-1:0];
  assign smp[5] = in_q.gyro_z[SAMPLE_WIDTH-1:0];

  assign launch_now = (calib_count_q >= calib_samples_q) ||
                      (FIELD_W'(smp[2]) < thresh_q);

  always_comb begin
    ctrl            = '0;
    ctrl.accum      = (state_q == ST_CALC) && !launch_q;
    ctrl.div_start  = (state_q == ST_DIV_INIT);
    ctrl.div_step   = (state_q == ST_DIV);
    ctrl.div_finish = (state_q == ST_FIX);
    ctrl.correct    = (state_q == ST_CALC) && launch_q;
    ctrl.mul        = (state_q == ST_MUL);
    ctrl.integ      = (state_q == ST_INTEG);
    ctrl.den        = {1'b0, calib_count_q} + DEN_W'(1);
  end

  assign load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d       = state_q;
    dcnt_d        = dcnt_q;
    calib_count_d = calib_count_q;
    launch_d      = launch_q;
    tick_d        = tick_q;
    post_d        = post_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        post_d = launch_q;
        if (launch_q) begin
          state_d = ST_MUL;
        end else if (launch_now) begin
          state_d = ST_DIV_INIT;
        end else begin
          state_d = ST_DONE;
          if (calib_count_q != {CNT_W{1'b1}}) begin
            calib_count_d = calib_count_q + CNT_W'(1);
          end
        end
      end
      ST_DIV_INIT: begin
        dcnt_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_LAST) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        launch_d = 1'b1;
        tick_d   = '0;
        state_d  = ST_DONE;
      end
      ST_MUL: begin
        state_d = ST_INTEG;
      end
      ST_INTEG: begin
        if (tick_q != {FIELD_W{1'b1}}) begin
          tick_d = tick_q + FIELD_W'(1);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      dcnt_q        <= '0;
      calib_count_q <= '0;
      launch_q      <= 1'b0;
      tick_q        <= '0;
      post_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      dcnt_q        <= dcnt_d;
      calib_count_q <= calib_count_d;
      launch_q      <= launch_d;
      tick_q        <= tick_d;
      post_q        <= post_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    imubc_lane #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .SUM_WIDTH   (SUM_WIDTH)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sample_i   (smp[g]),
      .corrected_o(corr[g])
    );
    assign sel[g] = post_q ? corr[g] : smp[g];
  end

  for (genvar g = 0; g < 3; g++) begin : g_integ
    imubc_integ #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_integ (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .dt_i   (dt_q),
      .rate_i (corr[3+g]),
      .angle_o(angle[g])
    );
  end

  always_comb begin
    out_d              = out_q;
    out_d.launched     = launch_q;
    out_d.flight_ticks = tick_q;
    out_d.acc_out_x    = FIELD_W'(sel[0]);
    out_d.acc_out_y    = FIELD_W'(sel[1]);
    out_d.acc_out_z    = FIELD_W'(sel[2]);
    out_d.rate_x       = FIELD_W'(sel[3]);
    out_d.rate_y       = FIELD_W'(sel[4]);
    out_d.rate_z       = FIELD_W'(sel[5]);
    out_d.roll         = angle[0];
    out_d.pitch        = angle[1];
    out_d.yaw          = angle[2];
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `IMUBC_ASSERT_IMPL(a_launch_sticky, clk_i, rst_ni, 1'b1, !$fell(launch_q), "launch flag fell")
  `IMUBC_ASSERT_NEXT(a_count_frozen, clk_i, rst_ni, launch_q, $stable(calib_count_q), "count moved after launch")
  `IMUBC_ASSERT_NEXT(a_div_end, clk_i, rst_ni, (state_q == ST_DIV) && (dcnt_q == DCNT_LAST), state_q == ST_FIX, "divider overran")
  `IMUBC_ASSERT_IMPL(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_DONE, "result without finished item")

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for imu_bias_calibrate_launch_integrate: calibration, launch,
// bias correction and angle integration checked transaction by transaction.
// Depends on imubc_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imubc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint S32_HI = 64'sd2147483647;

  typedef enum int {LAUNCH_FIRST, LAUNCH_AT_ONE, LAUNCH_BY_COUNT, LAUNCH_BY_ACCEL} launch_mode_e;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} stall_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  imu_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  imu_out_t              out_data;

  imu_bias_calibrate_launch_integrate u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies and the calibration/flight state of the block.
  int unsigned calib_limit = RST_CALIB_SAMPLES;
  longint      accel_thresh = longint'(RST_LAUNCH_THRESH);
  logic [23:0] dt_ticks = RST_DT_STEP;

  longint      axis_sum [6] = '{default: 0};
  longint      axis_bias[6] = '{default: 0};
  longint      angle    [3] = '{default: 0};
  int unsigned calib_n = 0;
  logic        in_flight = 1'b0;
  logic [31:0] flight_n = '0;

  imu_in_t  sample_q[$];
  imu_out_t due_results[$];

  int          errors = 0;
  int          result_n = 0;
  int          pre_n = 0;
  logic [0:5][31:0] lean;
  imu_out_t    want;

  int          tx_burst = 8;
  int          tx_gap = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  stall_mode_e rx_mode = RX_OPEN;
  int          rx_left = 0;
  int unsigned rx_tick = 0;

  function automatic longint clamp_s(input longint v, input longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Field order: accel x/y/z in slots 0..2, gyro x/y/z in slots 3..5.
  function automatic imu_out_t calib_integrate_step(input imu_in_t s);
    logic [0:5][31:0] f;
    longint raw [6];
    longint corr[6];
    longint acc;
    imu_out_t r;
    f = s;
    for (int i = 0; i < 6; i++) begin
      raw[i]  = longint'($signed(f[i]));
      corr[i] = raw[i];
    end
    if (!in_flight) begin
      for (int i = 0; i < 6; i++) begin
        axis_sum[i]  = clamp_s(axis_sum[i] + raw[i], SUM_HI);
        axis_bias[i] = clamp_s(axis_sum[i] / (longint'(calib_n) + 1), S32_HI);
      end
      if (calib_n >= calib_limit || raw[2] < accel_thresh) begin
        in_flight = 1'b1;
        flight_n  = '0;
      end else if (calib_n < 32'hFFFF) begin
        calib_n++;
      end
    end else begin
      for (int i = 0; i < 6; i++) corr[i] = clamp_s(raw[i] - axis_bias[i], S32_HI);
      for (int a = 0; a < 3; a++) begin
        acc = angle[a] * 64'sd16777216 + longint'(dt_ticks) * corr[3 + a] + 64'sd8388608;
        angle[a] = clamp_s(acc >>> 24, S32_HI);
      end
      if (flight_n != 32'hFFFF_FFFF) flight_n++;
    end
    r.launched     = in_flight;
    r.flight_ticks = flight_n;
    r.acc_out_x    = corr[0][31:0];
    r.acc_out_y    = corr[1][31:0];
    r.acc_out_z    = corr[2][31:0];
    r.rate_x       = corr[3][31:0];
    r.rate_y       = corr[4][31:0];
    r.rate_z       = corr[5][31:0];
    r.roll         = angle[0][31:0];
    r.pitch        = angle[1][31:0];
    r.yaw          = angle[2][31:0];
    return r;
  endfunction

  function automatic logic [31:0] rnd_field();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 511) - 32'd256;
      default: return $urandom();
    endcase
  endfunction

  function automatic imu_in_t rnd_item();
    logic [0:5][31:0] f;
    for (int i = 0; i < 6; i++) f[i] = rnd_field();
    return f;
  endfunction

  // Calibration samples lean toward one extreme per axis so that the biases come out large.
  function automatic imu_in_t calib_item();
    logic [0:5][31:0] f;
    for (int i = 0; i < 6; i++) f[i] = ($urandom_range(0, 3) != 0) ? lean[i] : rnd_field();
    if (longint'($signed(f[2])) < accel_thresh) f[2] = accel_thresh[31:0];
    return f;
  endfunction

  task automatic queue_pre(input imu_in_t it);
    sample_q.push_back(it);
    pre_n++;
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input longint val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[31:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CALIB_SAMPLES: calib_limit = val[15:0];
      CFG_LAUNCH_THRESH: accel_thresh = longint'($signed(val[31:0]));
      CFG_DT_STEP:       dt_ticks = val[23:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      if (errors <= 10)
        $display("tb: %s mismatch on result %0d: expected %h, got %h", name, result_n, exp_v, got_v);
    end
  endtask

  // Sender: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) due_results.push_back(calib_integrate_step(in_data));
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
          if (tx_burst <= 1) begin
            tx_burst <= $urandom_range(1, 60);
            tx_gap   <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 4);
          end else begin
            tx_burst <= tx_burst - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern of its own, plus a long hold-off on request.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= stall_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (rx_tick % 7) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: result %0d arrived with none expected", result_n);
      end else begin
        want = due_results.pop_front();
        check_field("launched", want.launched, out_data.launched);
        check_field("flight_ticks", want.flight_ticks, out_data.flight_ticks);
        check_field("rate_x", want.rate_x, out_data.rate_x);
        check_field("rate_y", want.rate_y, out_data.rate_y);
        check_field("rate_z", want.rate_z, out_data.rate_z);
        check_field("acc_out_x", want.acc_out_x, out_data.acc_out_x);
        check_field("acc_out_y", want.acc_out_y, out_data.acc_out_y);
        check_field("acc_out_z", want.acc_out_z, out_data.acc_out_z);
        check_field("roll", want.roll, out_data.roll);
        check_field("pitch", want.pitch, out_data.pitch);
        check_field("yaw", want.yaw, out_data.yaw);
      end
      result_n++;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

  initial begin : main
    launch_mode_e     mode;
    logic [0:5][31:0] f;
    logic [31:0]      thr;
    int unsigned      cs;
    int               need;
    logic [23:0]      dt_set[5];

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    mode = launch_mode_e'($urandom_range(0, 3));
    for (int i = 0; i < 6; i++) lean[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;

    if (mode == LAUNCH_FIRST) begin
      cfg_write(CFG_CALIB_SAMPLES, 0);
      queue_pre(calib_item());
    end else begin
      f = '{6{32'h7FFF_FFFF}};
      queue_pre(f);
      f = '{32'h8000_0000, 32'h8000_0000, RST_LAUNCH_THRESH, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000};
      queue_pre(f);
      f = '0;
      queue_pre(f);
      f = '{32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_0000};
      queue_pre(f);
      drain();

      cfg_write(CFG_LAUNCH_THRESH, longint'($signed(32'h8000_0000)));
      cfg_write(CFG_CALIB_SAMPLES, 65535);
      f = '{6{32'h8000_0000}};
      queue_pre(f);
      f = '{6{32'h7FFF_FFFF}};
      queue_pre(f);
      for (int k = 0; k < 35; k++) queue_pre(calib_item());
      drain();

      if (mode == LAUNCH_BY_ACCEL) begin
        thr = $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom();
        if (thr == 32'h8000_0000) thr = '0;
        cfg_write(CFG_LAUNCH_THRESH, longint'($signed(thr)));
        need = $urandom_range(2, 6);
        for (int k = 0; k < need; k++) queue_pre(calib_item());
        f = calib_item();
        f[2] = thr - 32'd1;
        queue_pre(f);
      end else begin
        cs = (mode == LAUNCH_AT_ONE) ? 1 : pre_n + $urandom_range(1, 4);
        cfg_write(CFG_CALIB_SAMPLES, cs);
        need = (cs > pre_n) ? cs - pre_n + 1 : 1;
        for (int k = 0; k < need; k++) queue_pre(calib_item());
      end
    end
    drain();

    f = '{6{32'h7FFF_FFFF}};
    sample_q.push_back(f);
    f = '{6{32'h8000_0000}};
    sample_q.push_back(f);
    f = '0;
    sample_q.push_back(f);
    f = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000};
    sample_q.push_back(f);
    f = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF};
    sample_q.push_back(f);
    drain();

    dt_set = '{RST_DT_STEP, 24'hFF_FFFF, 24'h0, 24'($urandom()), 24'($urandom_range(1, 4096))};
    for (int p = 0; p < 5; p++) begin
      cfg_write(CFG_DT_STEP, dt_set[p]);
      case (p)
        0: begin
          cfg_write(CFG_LAUNCH_THRESH, 32'h7FFF_FFFF);
          cfg_write(CFG_CALIB_SAMPLES, 65535);
        end
        1: begin
          cfg_write(CFG_LAUNCH_THRESH, longint'($signed(32'h8000_0000)));
          cfg_write(CFG_CALIB_SAMPLES, 1);
        end
        default: begin
          cfg_write(CFG_LAUNCH_THRESH, longint'($signed($urandom())));
          cfg_write(CFG_CALIB_SAMPLES, $urandom_range(1, 65535));
        end
      endcase
      for (int k = 0; k < 300; k++) sample_q.push_back(rnd_item());
      if (p == 1 || p == 3) begin
        @(posedge clk);
        hold_req <= hold_req + 1;
      end
      drain();
    end

    repeat (60) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/imubc_pkg.sv
rtl/core/imubc_lane.sv
rtl/core/imubc_integ.sv
rtl/core/imu_bias_calibrate_launch_integrate.sv
tb/sv/tb.sv
